### rtl/core/pfma_pkg.sv
package pfma_pkg;

    localparam int unsigned RES_W = 30;
    localparam int unsigned OPD_W = 64;
    localparam int unsigned EXP_W = 63;

    localparam logic [RES_W-1:0] FIELD_P  = 30'd1000000007;
    localparam logic [RES_W:0]   FIELD_P1 = 31'd1000000007;
    localparam logic [EXP_W-1:0] INV_EXP  = 63'd1000000005;

    typedef enum logic [2:0] {
        FN_REDUCE = 3'd0,
        FN_NEGATE = 3'd1,
        FN_ADD    = 3'd2,
        FN_SUB    = 3'd3,
        FN_MUL    = 3'd4,
        FN_POW    = 3'd5,
        FN_INV    = 3'd6,
        FN_DIV    = 3'd7
    } func_t;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_RED  = 9'b000000010,
        S_FIX  = 9'b000000100,
        S_DISP = 9'b000001000,
        S_MUL  = 9'b000010000,
        S_PSQ  = 9'b000100000,
        S_PBIT = 9'b001000000,
        S_PADV = 9'b010000000,
        S_OUT  = 9'b100000000
    } state_t;

    // what the multiplier result feeds once the serial product is done
    typedef enum logic [1:0] {
        MK_FINAL  = 2'd0,
        MK_SQUARE = 2'd1,
        MK_BASE   = 2'd2
    } mul_kind_t;

endpackage

### rtl/core/prime_field_modular_alu.sv
// Channel | Handshake              | Payload
// --------+------------------------+------------------------------------------
// request | req_valid / req_ready  | func, operand_a, operand_b, exponent
// response| rsp_valid / rsp_ready  | result
//
// One request at a time. Operand reduction shifts 64 bits in, one per cycle.
// Each modular product runs through a bit-serial shift-and-add unit, multiplier bits MSB first.
// Power, inverse and divide walk all 63 exponent bits with a square and, per set bit,
// a base product.
// rst_n clears the sequencer only; a response holds until rsp_ready, and req_ready is low
// from acceptance until the response beat is taken.
module prime_field_modular_alu
    import pfma_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_ready,
    input  logic [2:0]              func,
    input  logic signed [OPD_W-1:0] operand_a,
    input  logic signed [OPD_W-1:0] operand_b,
    input  logic [EXP_W-1:0]        exponent,
    output logic                    rsp_valid,
    input  logic                    rsp_ready,
    output logic [RES_W-1:0]        result
);

    state_t           state_reg,  state_next;
    func_t            func_reg,   func_next;
    mul_kind_t        kind_reg,   kind_next;
    logic [OPD_W-1:0] mag_a_reg,  mag_a_next;
    logic [OPD_W-1:0] mag_b_reg,  mag_b_next;
    logic             neg_a_reg,  neg_a_next;
    logic             neg_b_reg,  neg_b_next;
    logic [EXP_W-1:0] exp_reg,    exp_next;
    logic [RES_W-1:0] ra_reg,     ra_next;
    logic [RES_W-1:0] rb_reg,     rb_next;
    logic [RES_W-1:0] acc_reg,    acc_next;
    logic [RES_W-1:0] base_reg,   base_next;
    logic [RES_W-1:0] mx_reg,     mx_next;
    logic [RES_W-1:0] my_reg,     my_next;
    logic [RES_W-1:0] prod_reg,   prod_next;
    logic [RES_W-1:0] res_reg,    res_next;
    logic [5:0]       cnt_reg,    cnt_next;
    logic [5:0]       ecnt_reg,   ecnt_next;

    logic             req_beat;
    logic [RES_W:0]   red_a, red_b, dbl, dbl_r, msum, msum_r, add_s, sub_s;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_OUT);
    assign result    = res_reg;
    assign req_beat  = req_valid && req_ready;

    // serial reduction step: r = 2r + bit, one conditional subtract
    assign red_a = {ra_reg, mag_a_reg[OPD_W-1]};
    assign red_b = {rb_reg, mag_b_reg[OPD_W-1]};

    // interleaved modular product step, multiplier bits MSB first
    assign dbl    = {prod_reg, 1'b0};
    assign dbl_r  = (dbl >= FIELD_P1) ? dbl - FIELD_P1 : dbl;
    assign msum   = dbl_r + (mx_reg[RES_W-1] ? {1'b0, my_reg} : '0);
    assign msum_r = (msum >= FIELD_P1) ? msum - FIELD_P1 : msum;

    assign add_s = {1'b0, ra_reg} + {1'b0, rb_reg};
    assign sub_s = {1'b0, ra_reg} + FIELD_P1 - {1'b0, rb_reg};

    always_comb
    begin
        state_next = state_reg;
        func_next  = func_reg;
        kind_next  = kind_reg;
        mag_a_next = mag_a_reg;
        mag_b_next = mag_b_reg;
        neg_a_next = neg_a_reg;
        neg_b_next = neg_b_reg;
        exp_next   = exp_reg;
        ra_next    = ra_reg;
        rb_next    = rb_reg;
        acc_next   = acc_reg;
        base_next  = base_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        prod_next  = prod_reg;
        res_next   = res_reg;
        cnt_next   = cnt_reg;
        ecnt_next  = ecnt_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_beat)
                begin
                    func_next  = func_t'(func);
                    neg_a_next = operand_a[OPD_W-1];
                    neg_b_next = operand_b[OPD_W-1];
                    mag_a_next = operand_a[OPD_W-1] ? 64'(-operand_a) : operand_a;
                    mag_b_next = operand_b[OPD_W-1] ? 64'(-operand_b) : operand_b;
                    exp_next   = (func_t'(func) == FN_POW) ? exponent : INV_EXP;
                    ra_next    = '0;
                    rb_next    = '0;
                    cnt_next   = 6'd63;
                    state_next = S_RED;
                end
            end
            S_RED:
            begin
                ra_next    = (red_a >= FIELD_P1) ? 30'(red_a - FIELD_P1) : red_a[RES_W-1:0];
                rb_next    = (red_b >= FIELD_P1) ? 30'(red_b - FIELD_P1) : red_b[RES_W-1:0];
                mag_a_next = {mag_a_reg[OPD_W-2:0], 1'b0};
                mag_b_next = {mag_b_reg[OPD_W-2:0], 1'b0};
                cnt_next   = cnt_reg - 6'd1;
                if (cnt_reg == '0)
                    state_next = S_FIX;
            end
            S_FIX:
            begin
                if (neg_a_reg && ra_reg != '0)
                    ra_next = FIELD_P - ra_reg;
                if (neg_b_reg && rb_reg != '0)
                    rb_next = FIELD_P - rb_reg;
                state_next = S_DISP;
            end
            S_DISP:
            begin
                state_next = S_OUT;
                case (func_reg)
                    FN_REDUCE: res_next = ra_reg;
                    FN_NEGATE: res_next = (ra_reg == '0) ? '0 : FIELD_P - ra_reg;
                    FN_ADD:    res_next = (add_s >= FIELD_P1) ? 30'(add_s - FIELD_P1)
                                                              : add_s[RES_W-1:0];
                    FN_SUB:    res_next = (ra_reg >= rb_reg) ? ra_reg - rb_reg
                                                             : sub_s[RES_W-1:0];
                    FN_MUL:
                    begin
                        mx_next    = ra_reg;
                        my_next    = rb_reg;
                        prod_next  = '0;
                        cnt_next   = 6'(RES_W - 1);
                        kind_next  = MK_FINAL;
                        state_next = S_MUL;
                    end
                    default:
                    begin
                        acc_next   = 30'd1;
                        base_next  = (func_reg == FN_DIV) ? rb_reg : ra_reg;
                        ecnt_next  = 6'(EXP_W - 1);
                        state_next = S_PSQ;
                    end
                endcase
            end
            S_MUL:
            begin
                prod_next = msum_r[RES_W-1:0];
                mx_next   = {mx_reg[RES_W-2:0], 1'b0};
                cnt_next  = cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    case (kind_reg)
                        MK_SQUARE:
                        begin
                            acc_next   = msum_r[RES_W-1:0];
                            state_next = S_PBIT;
                        end
                        MK_BASE:
                        begin
                            acc_next   = msum_r[RES_W-1:0];
                            state_next = S_PADV;
                        end
                        default:
                        begin
                            res_next   = msum_r[RES_W-1:0];
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_PSQ:
            begin
                mx_next    = acc_reg;
                my_next    = acc_reg;
                prod_next  = '0;
                cnt_next   = 6'(RES_W - 1);
                kind_next  = MK_SQUARE;
                state_next = S_MUL;
            end
            S_PBIT:
            begin
                if (exp_reg[EXP_W-1])
                begin
                    mx_next    = acc_reg;
                    my_next    = base_reg;
                    prod_next  = '0;
                    cnt_next   = 6'(RES_W - 1);
                    kind_next  = MK_BASE;
                    state_next = S_MUL;
                end
                else
                    state_next = S_PADV;
            end
            S_PADV:
            begin
                exp_next  = {exp_reg[EXP_W-2:0], 1'b0};
                ecnt_next = ecnt_reg - 6'd1;
                if (ecnt_reg != '0)
                    state_next = S_PSQ;
                else if (func_reg == FN_DIV)
                begin
                    mx_next    = ra_reg;
                    my_next    = acc_reg;
                    prod_next  = '0;
                    cnt_next   = 6'(RES_W - 1);
                    kind_next  = MK_FINAL;
                    state_next = S_MUL;
                end
                else
                begin
                    res_next   = acc_reg;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (rsp_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        func_reg  <= func_next;
        kind_reg  <= kind_next;
        mag_a_reg <= mag_a_next;
        mag_b_reg <= mag_b_next;
        neg_a_reg <= neg_a_next;
        neg_b_reg <= neg_b_next;
        exp_reg   <= exp_next;
        ra_reg    <= ra_next;
        rb_reg    <= rb_next;
        acc_reg   <= acc_next;
        base_reg  <= base_next;
        mx_reg    <= mx_next;
        my_reg    <= my_next;
        prod_reg  <= prod_next;
        res_reg   <= res_next;
        cnt_reg   <= cnt_next;
        ecnt_reg  <= ecnt_next;
    end

`ifndef SYNTHESIS
    a_result_in_field: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (result < FIELD_P))
        else $error("result not a residue");

    a_acc_in_field: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PSQ || state_reg == S_PBIT || state_reg == S_PADV)
            |-> (acc_reg < FIELD_P && base_reg < FIELD_P))
        else $error("power accumulator out of range");

    a_prod_in_field: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (prod_reg < FIELD_P && my_reg < FIELD_P))
        else $error("serial product out of range");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && rsp_valid))
        else $error("request taken while response pending");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        req_beat |=> (state_reg == S_RED && !rsp_valid))
        else $error("accepted beat did not start reduction");
`endif

endmodule
